>>> sv/spr_pkg.sv
// shared types and constants for the period based speedometer
`timescale 1ns / 1ps

package spr_pkg;

   localparam int PERIOD_BITS    = 24;
   localparam int RATE_W         = 24;
   localparam int REF_W          = 36;
   localparam int NUM_W          = 41;
   localparam int SPEED_W        = 16;
   localparam int STEP_W         = 8;
   localparam int DIGIT_W        = 4;
   localparam int CLAMP_W        = 10;
   localparam int REM_W          = 7;
   localparam int DIV_CNT_W      = 6;

   localparam logic [NUM_W-1:0]   RATE_NUM       = NUM_W'(10000000);
   localparam logic [REF_W-1:0]   SEC_PER_HOUR   = REF_W'(3600);
   localparam logic [NUM_W-1:0]   CAL_FACTOR     = NUM_W'(3600 * 60);
   localparam logic [SPEED_W-1:0] DIGIT_CLAMP    = SPEED_W'(999);
   localparam logic [SPEED_W-1:0] BLANK_LIMIT    = SPEED_W'(99);
   localparam logic [SPEED_W-1:0] SPEED_MAX      = {SPEED_W{1'b1}};
   localparam logic [STEP_W-1:0]  MAX_STEP_RESET = STEP_W'(35);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(NUM_W - 1);

   // reciprocal constants for the decimal split
   localparam logic [10:0] RECIP_HUNDRED = 11'd1311;
   localparam int          SHIFT_HUNDRED = 17;
   localparam logic [7:0]  RECIP_TEN     = 8'd205;
   localparam int          SHIFT_TEN     = 11;
   localparam logic [REM_W-1:0] HUNDRED  = REM_W'(100);
   localparam logic [DIGIT_W-1:0] TEN    = DIGIT_W'(10);

   typedef enum logic {
      OP_CALIBRATE = 1'b0,
      OP_MEASURE   = 1'b1
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [PERIOD_BITS-1:0] period;
      logic                   seen;
      logic                   period_zero;
   } item_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [REF_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> sv/spr_front.sv
// request queue and classification in front of the compute sequencer
`timescale 1ns / 1ps

module spr_front import spr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_op,
   input  logic [PERIOD_BITS-1:0] req_period_count,
   input  logic                   req_pulses_seen,
   output logic                   item_valid,
   output item_type               item,
   input  logic                   item_take
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push_ok;
   logic       pop_ok;
   item_type   new_item;

   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_take && item_valid;

   always_comb begin
      new_item.op          = op_type'(req_op);
      new_item.period      = req_period_count;
      new_item.seen        = req_pulses_seen;
      new_item.period_zero = (req_period_count == '0);
   end

   always_comb begin
      count_in = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push_ok) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_ok) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> sv/spr_div.sv
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps

module spr_div import spr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [REF_W-1:0]     rem_ff;
   logic [NUM_W-1:0]     quo_ff;
   logic [REF_W-1:0]     divisor_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [REF_W:0]       rem_shift;
   logic [REF_W+1:0]     trial;

   assign rem_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, divisor_ff};

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && count_ff == DIV_LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff     <= '0;
         quo_ff     <= div_req.dividend;
         divisor_ff <= div_req.divisor;
         count_ff   <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + DIV_CNT_W'(1);
         if (!trial[REF_W+1]) begin
            rem_ff <= trial[REF_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[REF_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

endmodule

>>> sv/spr_back.sv
// compute sequencer: rate, reference, speed, spike filter and result register
`timescale 1ns / 1ps

module spr_back import spr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  item_type            item,
   output logic                item_take,
   input  logic [STEP_W-1:0]   max_step,
   output div_req_type         div_req,
   input  div_rsp_type         div_rsp,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [SPEED_W-1:0]  rsp_speed,
   output logic [DIGIT_W-1:0]  rsp_digit_hundreds,
   output logic [DIGIT_W-1:0]  rsp_digit_tens,
   output logic [DIGIT_W-1:0]  rsp_digit_ones,
   output logic                rsp_blank_hundreds,
   output logic                rsp_spike_rejected
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATE_WAIT,
      ST_MUL,
      ST_DECIDE,
      ST_SPEED_WAIT,
      ST_FILTER,
      ST_OUT
   } state_type;

   state_type          state_ff;
   op_type             op_ff;
   logic               seen_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic [REF_W-1:0]   cal_prod_ff;
   logic [NUM_W-1:0]   meas_prod_ff;
   logic [REF_W-1:0]   ref_ff;
   logic [SPEED_W-1:0] raw_ff;
   logic [SPEED_W-1:0] prev_ff;
   logic               armed_ff;
   logic [SPEED_W-1:0] spd_ff;
   logic               rej_ff;
   logic               out_valid_ff;

   logic [REF_W-1:0]   cal_prod_in;
   logic [NUM_W-1:0]   meas_prod_in;
   logic [SPEED_W-1:0] raw_in;
   logic [SPEED_W:0]   rise;
   logic               spike;
   logic               out_free;

   // decimal split
   logic [CLAMP_W-1:0] clamped;
   logic [20:0]        hund_prod;
   logic [DIGIT_W-1:0] hund;
   logic [REM_W-1:0]   below_hund;
   logic [14:0]        ten_prod;
   logic [DIGIT_W-1:0] tens;
   logic [DIGIT_W-1:0] ones;
   logic [REM_W-1:0]   hund_part;
   logic [DIGIT_W-1:0] ten_part;

   assign cal_prod_in  = REF_W'(rate_ff) * SEC_PER_HOUR;
   assign meas_prod_in = NUM_W'(rate_ff) * CAL_FACTOR;
   assign raw_in       = (div_rsp.quotient > NUM_W'(SPEED_MAX)) ? SPEED_MAX
                         : div_rsp.quotient[SPEED_W-1:0];
   assign rise         = {1'b0, raw_ff} - {1'b0, prev_ff};
   assign spike        = armed_ff && (raw_ff > prev_ff)
                         && (rise > (SPEED_W + 1)'(max_step));
   assign out_free     = !out_valid_ff || rsp_pop;

   assign clamped    = (spd_ff > DIGIT_CLAMP) ? DIGIT_CLAMP[CLAMP_W-1:0]
                       : spd_ff[CLAMP_W-1:0];
   assign hund_prod  = 21'(clamped) * 21'(RECIP_HUNDRED);
   assign hund       = hund_prod[SHIFT_HUNDRED+DIGIT_W-1:SHIFT_HUNDRED];
   assign hund_part  = REM_W'(hund) * HUNDRED;
   assign below_hund = REM_W'(clamped - CLAMP_W'(hund_part))
                       ^ REM_W'(CLAMP_W'(hund) * CLAMP_W'(0));
   assign ten_prod   = 15'(below_hund) * 15'(RECIP_TEN);
   assign tens       = ten_prod[SHIFT_TEN+DIGIT_W-1:SHIFT_TEN];
   assign ten_part   = DIGIT_W'(tens * TEN);
   assign ones       = DIGIT_W'(below_hund) - ten_part;

   assign item_take = (state_ff == ST_IDLE) && item_valid;
   assign rsp_empty = !out_valid_ff;

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = RATE_NUM;
      div_req.divisor  = REF_W'(item.period);
      if (state_ff == ST_IDLE) begin
         div_req.start = item_valid && !item.period_zero;
      end else if (state_ff == ST_DECIDE) begin
         div_req.start    = (op_ff == OP_MEASURE) && seen_ff && (ref_ff != '0);
         div_req.dividend = meas_prod_ff;
         div_req.divisor  = ref_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ref_ff       <= '0;
         prev_ff      <= '0;
         armed_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && out_valid_ff && state_ff != ST_OUT) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  op_ff   <= item.op;
                  seen_ff <= item.seen;
                  rate_ff <= '0;
                  state_ff <= item.period_zero ? ST_MUL : ST_RATE_WAIT;
               end
            end
            ST_RATE_WAIT: begin
               if (div_rsp.done) begin
                  rate_ff  <= div_rsp.quotient[RATE_W-1:0];
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               cal_prod_ff  <= cal_prod_in;
               meas_prod_ff <= meas_prod_in;
               state_ff     <= ST_DECIDE;
            end
            ST_DECIDE: begin
               raw_ff <= '0;
               if (op_ff == OP_CALIBRATE) begin
                  ref_ff   <= cal_prod_ff;
                  armed_ff <= 1'b0;
                  spd_ff   <= '0;
                  rej_ff   <= 1'b0;
                  state_ff <= ST_OUT;
               end else if (seen_ff && ref_ff != '0) begin
                  state_ff <= ST_SPEED_WAIT;
               end else begin
                  state_ff <= ST_FILTER;
               end
            end
            ST_SPEED_WAIT: begin
               if (div_rsp.done) begin
                  raw_ff   <= raw_in;
                  state_ff <= ST_FILTER;
               end
            end
            ST_FILTER: begin
               if (spike) begin
                  spd_ff   <= prev_ff;
                  rej_ff   <= 1'b1;
                  armed_ff <= 1'b0;
               end else begin
                  spd_ff   <= raw_ff;
                  prev_ff  <= raw_ff;
                  rej_ff   <= 1'b0;
                  armed_ff <= 1'b1;
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  out_valid_ff       <= 1'b1;
                  rsp_speed          <= spd_ff;
                  rsp_digit_hundreds <= hund;
                  rsp_digit_tens     <= tens;
                  rsp_digit_ones     <= ones;
                  rsp_blank_hundreds <= (spd_ff <= BLANK_LIMIT);
                  rsp_spike_rejected <= rej_ff;
                  state_ff           <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> sv/speed_from_period_with_spike_reject_top.sv
// top level of the period based speedometer with spike rejection
`timescale 1ns / 1ps

// Each request carries an op, a pulse period and a pulses-seen flag and gives
// exactly one response. Its timing is set by the shared serial divider, which
// produces one quotient bit per cycle over 41 bits, once for the rate and,
// for a measure request, once more for the speed. A period of zero skips
// the rate division, and a measure with no pulses or no calibration skips
// the speed division. Up to two requests queue ahead of the sequencer and
// one finished response waits in the output register. max_step is written
// through the csr channel, which is always ready, and should only change
// while no request is in flight.

module speed_from_period_with_spike_reject_top import spr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_op,
   input  logic [PERIOD_BITS-1:0] req_period_count,
   input  logic                   req_pulses_seen,
   output logic                   empty,
   input  logic                   pop,
   output logic [SPEED_W-1:0]     rsp_speed,
   output logic [DIGIT_W-1:0]     rsp_digit_hundreds,
   output logic [DIGIT_W-1:0]     rsp_digit_tens,
   output logic [DIGIT_W-1:0]     rsp_digit_ones,
   output logic                   rsp_blank_hundreds,
   output logic                   rsp_spike_rejected,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [STEP_W-1:0]      csr_max_step
);

   logic [STEP_W-1:0] max_step_ff;
   logic              item_valid;
   item_type          item;
   logic              item_take;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff <= MAX_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         max_step_ff <= csr_max_step;
      end
   end

   spr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (push),
      .req_full         (full),
      .req_op           (req_op),
      .req_period_count (req_period_count),
      .req_pulses_seen  (req_pulses_seen),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take)
   );

   spr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   spr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (item_valid),
      .item               (item),
      .item_take          (item_take),
      .max_step           (max_step_ff),
      .div_req            (div_req),
      .div_rsp            (div_rsp),
      .rsp_empty          (empty),
      .rsp_pop            (pop),
      .rsp_speed          (rsp_speed),
      .rsp_digit_hundreds (rsp_digit_hundreds),
      .rsp_digit_tens     (rsp_digit_tens),
      .rsp_digit_ones     (rsp_digit_ones),
      .rsp_blank_hundreds (rsp_blank_hundreds),
      .rsp_spike_rejected (rsp_spike_rejected)
   );

endmodule

>>> bench/tb_speed_from_period_with_spike_reject_top.sv
// testbench for the period based speedometer with spike rejection
`timescale 1ns / 1ps

module tb_speed_from_period_with_spike_reject_top;
   import spr_pkg::*;

   localparam int unsigned HOLD_CYCLES    = 500;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned SETTLE_CYCLES  = 200;
   localparam int unsigned PERIOD_MAX     = (1 << PERIOD_BITS) - 1;
   localparam longint unsigned TICK_RATE        = 10000000;
   localparam longint unsigned SECONDS_PER_HOUR = 3600;
   localparam longint unsigned CAL_KMH          = 60;
   localparam longint unsigned REFERENCE_MASK   = (64'd1 << REF_W) - 1;
   localparam int unsigned SHOWN_LIMIT    = 999;
   localparam int unsigned BLANK_BELOW    = 99;

   typedef struct {
      logic [SPEED_W-1:0] speed;
      logic [DIGIT_W-1:0] hundreds;
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] ones;
      logic               blank;
      logic               rejected;
   } reading_type;

   logic                   clock;
   logic                   reset;
   logic                   push = 1'b0;
   logic                   full;
   logic                   req_op = 1'b0;
   logic [PERIOD_BITS-1:0] req_period_count = '0;
   logic                   req_pulses_seen = 1'b0;
   logic                   empty;
   logic                   pop = 1'b0;
   logic [SPEED_W-1:0]     rsp_speed;
   logic [DIGIT_W-1:0]     rsp_digit_hundreds;
   logic [DIGIT_W-1:0]     rsp_digit_tens;
   logic [DIGIT_W-1:0]     rsp_digit_ones;
   logic                   rsp_blank_hundreds;
   logic                   rsp_spike_rejected;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [STEP_W-1:0]      csr_max_step = '0;

   // predictor state
   longint unsigned    cal_reference;
   logic [SPEED_W-1:0] last_speed;
   bit                 filter_armed;
   logic [STEP_W-1:0]  step_limit;

   reading_type pending_readings[$];
   reading_type oldest_reading;
   int          error_count = 0;
   int          burst_left = 0;
   bit          hold_request = 1'b0;
   bit          hold_active = 1'b0;
   int unsigned idle_cycles = 0;
   logic [15:0] stall_pattern = '1;
   int          stall_phase = 0;

   speed_from_period_with_spike_reject_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_op             (req_op),
      .req_period_count   (req_period_count),
      .req_pulses_seen    (req_pulses_seen),
      .empty              (empty),
      .pop                (pop),
      .rsp_speed          (rsp_speed),
      .rsp_digit_hundreds (rsp_digit_hundreds),
      .rsp_digit_tens     (rsp_digit_tens),
      .rsp_digit_ones     (rsp_digit_ones),
      .rsp_blank_hundreds (rsp_blank_hundreds),
      .rsp_spike_rejected (rsp_spike_rejected),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_step       (csr_max_step)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic reading_type predict_reading(op_type op,
                                                   logic [PERIOD_BITS-1:0] period,
                                                   logic seen);
      longint unsigned    rate;
      longint unsigned    quotient;
      logic [SPEED_W-1:0] raw;
      logic [SPEED_W-1:0] shown;
      int unsigned        clamped;
      reading_type        r;
      rate = (period == 0) ? 0 : TICK_RATE / period;
      raw = '0;
      r.rejected = 1'b0;
      if (op == OP_CALIBRATE) begin
         cal_reference = (rate * SECONDS_PER_HOUR) & REFERENCE_MASK;
         filter_armed = 1'b0;
         shown = '0;
      end else begin
         if (seen && cal_reference != 0) begin
            quotient = (rate * SECONDS_PER_HOUR * CAL_KMH) / cal_reference;
            raw = (quotient > SPEED_MAX) ? SPEED_MAX : quotient[SPEED_W-1:0];
         end
         if (filter_armed && raw > last_speed && (raw - last_speed) > step_limit) begin
            shown = last_speed;
            filter_armed = 1'b0;
            r.rejected = 1'b1;
         end else begin
            last_speed = raw;
            filter_armed = 1'b1;
            shown = raw;
         end
      end
      clamped = (shown > SHOWN_LIMIT) ? SHOWN_LIMIT : shown;
      r.speed = shown;
      r.hundreds = DIGIT_W'(clamped / 100);
      r.tens = DIGIT_W'((clamped / 10) % 10);
      r.ones = DIGIT_W'(clamped % 10);
      r.blank = (shown <= BLANK_BELOW);
      return r;
   endfunction

   task automatic send_request(op_type op, logic [PERIOD_BITS-1:0] period, logic seen);
      int gap;
      if (burst_left == 0) begin
         @(negedge clock);
         push <= 1'b0;
         gap = $urandom_range(0, 12);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
      @(negedge clock);
      push <= 1'b1;
      req_op <= op;
      req_period_count <= period;
      req_pulses_seen <= seen;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_readings.push_back(predict_reading(op, period, seen));
      burst_left--;
   endtask

   task automatic wait_for_readings();
      @(negedge clock);
      push <= 1'b0;
      burst_left = 0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_max_step(logic [STEP_W-1:0] value);
      wait_for_readings();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_max_step <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      step_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // calibrate, then a walk of speeds with jumps, noise and recalibrations
   task automatic drive_sequence(int count);
      longint unsigned cal_period;
      longint unsigned guess;
      int              target;
      int              window;
      int unsigned     pick;
      case ($urandom_range(0, 9))
         0: cal_period = 0;
         1: cal_period = $urandom_range(1, 1999);
         2: cal_period = $urandom_range(200001, PERIOD_MAX);
         default: cal_period = $urandom_range(2000, 200000);
      endcase
      send_request(OP_CALIBRATE, PERIOD_BITS'(cal_period), 1'($urandom_range(0, 1)));
      target = $urandom_range(0, 150);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_request(op_type'($urandom_range(0, 1)),
                         PERIOD_BITS'($urandom_range(0, PERIOD_MAX)),
                         1'($urandom_range(0, 1)));
         end else if (pick < 10) begin
            send_request(OP_CALIBRATE, PERIOD_BITS'(cal_period), 1'b1);
         end else if (pick < 13) begin
            send_request(OP_MEASURE, '0, 1'b1);
         end else begin
            window = int'(step_limit) + 4;
            if ($urandom_range(0, 9) < 8)
               target = target + int'($urandom_range(0, 2 * window)) - window;
            else
               target = $urandom_range(0, 1500);
            if (target < 0) target = 0;
            if (target > 2000) target = 2000;
            if (target == 0) begin
               send_request(OP_MEASURE, PERIOD_BITS'($urandom_range(0, PERIOD_MAX)), 1'b0);
            end else begin
               guess = (cal_period * CAL_KMH) / target;
               if (guess == 0) guess = 1;
               if (guess > PERIOD_MAX) guess = PERIOD_MAX;
               send_request(OP_MEASURE, PERIOD_BITS'(guess), 1'b1);
            end
         end
      end
   endtask

   task automatic test_directed_cases();
      send_request(OP_MEASURE, 24'd100000, 1'b1);
      send_request(OP_CALIBRATE, 24'd0, 1'b1);
      send_request(OP_MEASURE, 24'd100000, 1'b1);
      send_request(OP_CALIBRATE, 24'd10000, 1'b0);
      send_request(OP_MEASURE, 24'd10000, 1'b1);
      send_request(OP_MEASURE, 24'd10000, 1'b0);
      send_request(OP_MEASURE, 24'd10000, 1'b1);
      send_request(OP_MEASURE, 24'd10000, 1'b1);
      send_request(OP_MEASURE, 24'd0, 1'b1);
      send_request(OP_MEASURE, 24'd10000, 1'b1);
      send_request(OP_MEASURE, 24'd7500, 1'b1);
      send_request(OP_MEASURE, 24'd6060, 1'b1);
      send_request(OP_MEASURE, 24'd5998, 1'b1);
      send_request(OP_MEASURE, 24'd600, 1'b1);
      send_request(OP_MEASURE, 24'd600, 1'b1);
      send_request(OP_MEASURE, 24'd599, 1'b1);
      send_request(OP_MEASURE, 24'd1, 1'b1);
      send_request(OP_MEASURE, 24'd1, 1'b1);
      send_request(OP_MEASURE, 24'hFFFFFF, 1'b1);
      send_request(OP_CALIBRATE, 24'd1, 1'b1);
      send_request(OP_MEASURE, 24'd1, 1'b1);
      send_request(OP_MEASURE, 24'd2, 1'b1);
      send_request(OP_CALIBRATE, 24'hFFFFFF, 1'b1);
      send_request(OP_MEASURE, 24'd5000, 1'b1);
   endtask

   task automatic test_step_extremes();
      write_max_step(8'd0);
      drive_sequence(60);
      write_max_step(8'd255);
      drive_sequence(60);
      write_max_step(8'd1);
      drive_sequence(60);
   endtask

   task automatic test_full_stall();
      hold_request = 1'b1;
      burst_left = 40;
      repeat (24)
         send_request(OP_MEASURE, PERIOD_BITS'($urandom_range(1, 200000)), 1'b1);
   endtask

   task automatic test_drain_pause();
      repeat (3) begin
         drive_sequence(30);
         wait_for_readings();
      end
   endtask

   task automatic test_random_sequences();
      for (int i = 0; i < 14; i++) begin
         if (i % 2 == 0) write_max_step(STEP_W'($urandom_range(0, 255)));
         drive_sequence($urandom_range(40, 120));
      end
   endtask

   initial begin
      reset = 1'b1;
      cal_reference = 0;
      last_speed = '0;
      filter_armed = 1'b0;
      step_limit = MAX_STEP_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_step_extremes();
      test_full_stall();
      test_drain_pause();
      test_random_sequences();
      wait_for_readings();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // long receiver hold-off so the request side backs up
   initial begin
      forever begin
         wait (hold_request);
         @(posedge clock);
         hold_active = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active = 1'b0;
         hold_request = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (stall_phase == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern = '1;
            1: stall_pattern = 16'($urandom);
            2: stall_pattern = 16'($urandom & $urandom);
            default: stall_pattern = 16'($urandom | $urandom);
         endcase
      end
      pop <= !hold_active && stall_pattern[stall_phase];
      stall_phase = (stall_phase + 1) % 16;
   end

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_readings.size() == 0) begin
            $error("response with no request outstanding: speed %0d", rsp_speed);
            error_count++;
         end else begin
            oldest_reading = pending_readings.pop_front();
            compare_field("speed", oldest_reading.speed, rsp_speed);
            compare_field("digit_hundreds", oldest_reading.hundreds, rsp_digit_hundreds);
            compare_field("digit_tens", oldest_reading.tens, rsp_digit_tens);
            compare_field("digit_ones", oldest_reading.ones, rsp_digit_ones);
            compare_field("blank_hundreds", oldest_reading.blank, rsp_blank_hundreds);
            compare_field("spike_rejected", oldest_reading.rejected, rsp_spike_rejected);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

>>> speed_from_period_with_spike_reject_top.f
sv/spr_pkg.sv
sv/spr_front.sv
sv/spr_div.sv
sv/spr_back.sv
sv/speed_from_period_with_spike_reject_top.sv
bench/tb_speed_from_period_with_spike_reject_top.sv
